/* sv/hpd_pkg.sv */
// ----------------------------------------------------------------------------
// hpd_pkg: shared types and constants for the packed Hamming(12,8) decoder
// Holds the codeword masks, field widths, register map and the beat struct
// passed from the unpack stage to the decode stage.
// ----------------------------------------------------------------------------
package hpd_pkg;

   localparam int CodeByteWidth = 8;
   localparam int CwWidth       = 12;
   localparam int SynWidth      = 4;
   localparam int NibbleWidth   = 4;

   // parity check masks, codeword bit 11 is Hamming position 1
   localparam logic [CwWidth-1:0] MaskP1 = 12'h2AA;
   localparam logic [CwWidth-1:0] MaskP2 = 12'h266;
   localparam logic [CwWidth-1:0] MaskP4 = 12'h0E1;
   localparam logic [CwWidth-1:0] MaskP8 = 12'h00F;

   // codeword bits that carry the parity of each check
   localparam int ParBitP1 = 11;
   localparam int ParBitP2 = 10;
   localparam int ParBitP4 = 8;
   localparam int ParBitP8 = 4;

   localparam logic [SynWidth-1:0] LastCorrectable = 4'd12;

   // register map
   localparam int CsrDataWidth  = 32;
   localparam int CsrAddrWidth  = 3;
   localparam int CsrIndexWidth = 1;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CORRECT_MODE = 1'b0
   } csr_index_type;

   // one completed codeword headed for the decode stage
   typedef struct packed {
      logic               valid;
      logic [CwWidth-1:0] cw;
   } cw_beat_type;

endpackage

/* sv/hpd_csr.sv */
// ----------------------------------------------------------------------------
// hpd_csr: configuration register block
// APB-style slave holding the correct_mode control bit.
// ----------------------------------------------------------------------------
module hpd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [hpd_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [hpd_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [hpd_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                             csr_pready,
   output logic                             correct_mode
);

   logic                       correct_mode_ff;
   logic                       correct_mode_in;
   logic                       wr_en;
   hpd_pkg::csr_index_type     reg_index;

   assign reg_index  = hpd_pkg::csr_index_type'(csr_paddr[hpd_pkg::CsrAddrWidth-1 -:
                                                         hpd_pkg::CsrIndexWidth]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      correct_mode_in = correct_mode_ff;
      if (wr_en && (reg_index == hpd_pkg::CSR_CORRECT_MODE)) begin
         correct_mode_in = csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == hpd_pkg::CSR_CORRECT_MODE) begin
         csr_prdata = {{(hpd_pkg::CsrDataWidth-1){1'b0}}, correct_mode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         correct_mode_ff <= 1'b0;
      end else begin
         correct_mode_ff <= correct_mode_in;
      end
   end

   assign correct_mode = correct_mode_ff;

endmodule

/* sv/hpd_unpack.sv */
// ----------------------------------------------------------------------------
// hpd_unpack: byte stream to codeword unpacker
// Tracks the byte phase within each three-byte group, holds the leftover
// byte or nibble, and registers each completed 12-bit codeword.
// ----------------------------------------------------------------------------
module hpd_unpack (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [hpd_pkg::CodeByteWidth-1:0] req_code_byte,
   output hpd_pkg::cw_beat_type              cw_beat,
   input  logic                              cw_ready
);

   typedef enum logic [1:0] {
      PH_A = 2'd0,
      PH_B = 2'd1,
      PH_C = 2'd2
   } phase_type;

   phase_type                          phase_ff;
   phase_type                          phase_in;
   logic [hpd_pkg::CodeByteWidth-1:0]  held_ff;
   logic [hpd_pkg::CodeByteWidth-1:0]  held_in;
   logic [hpd_pkg::CwWidth-1:0]        cw_ff;
   logic [hpd_pkg::CwWidth-1:0]        cw_in;
   logic                               valid_ff;
   logic                               valid_in;
   logic                               accept;

   assign req_ready = !valid_ff || cw_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      cw_in    = cw_ff;
      valid_in = valid_ff && !cw_ready;
      if (accept) begin
         unique case (phase_ff)
            PH_B: begin
               cw_in    = {held_ff, req_code_byte[7:4]};
               held_in  = {{(hpd_pkg::CodeByteWidth-hpd_pkg::NibbleWidth){1'b0}},
                           req_code_byte[3:0]};
               phase_in = PH_C;
               valid_in = 1'b1;
            end
            PH_C: begin
               cw_in    = {held_ff[hpd_pkg::NibbleWidth-1:0], req_code_byte};
               phase_in = PH_A;
               valid_in = 1'b1;
            end
            default: begin
               held_in  = req_code_byte;
               phase_in = PH_B;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_A;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
      held_ff <= held_in;
      cw_ff   <= cw_in;
   end

   assign cw_beat.valid = valid_ff;
   assign cw_beat.cw    = cw_ff;

endmodule

/* sv/hpd_decode.sv */
// ----------------------------------------------------------------------------
// hpd_decode: syndrome, correction and result register
// Computes the Hamming syndrome of one codeword, optionally flips the
// addressed bit, extracts the data byte and registers the result beat.
// ----------------------------------------------------------------------------
module hpd_decode (
   input  logic                              clock,
   input  logic                              reset,
   input  hpd_pkg::cw_beat_type              cw_beat,
   output logic                              cw_ready,
   input  logic                              correct_mode,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [hpd_pkg::CodeByteWidth-1:0] rsp_data_byte,
   output logic [hpd_pkg::SynWidth-1:0]      rsp_syndrome,
   output logic                              rsp_error_flag,
   output logic                              rsp_uncorrectable
);

   logic [hpd_pkg::SynWidth-1:0]      syn;
   logic [hpd_pkg::CwWidth-1:0]       flip;
   logic [hpd_pkg::CwWidth-1:0]       fixed_cw;
   logic                              load;

   logic                              valid_ff;
   logic                              valid_in;
   logic [hpd_pkg::CodeByteWidth-1:0] data_ff;
   logic [hpd_pkg::CodeByteWidth-1:0] data_in;
   logic [hpd_pkg::SynWidth-1:0]      syn_ff;
   logic                              err_ff;
   logic                              err_in;
   logic                              bad_ff;
   logic                              bad_in;

   assign cw_ready = !valid_ff || rsp_ready;
   assign load     = cw_beat.valid && cw_ready;

   always_comb begin
      syn[0] = ^(cw_beat.cw & hpd_pkg::MaskP1) ^ cw_beat.cw[hpd_pkg::ParBitP1];
      syn[1] = ^(cw_beat.cw & hpd_pkg::MaskP2) ^ cw_beat.cw[hpd_pkg::ParBitP2];
      syn[2] = ^(cw_beat.cw & hpd_pkg::MaskP4) ^ cw_beat.cw[hpd_pkg::ParBitP4];
      syn[3] = ^(cw_beat.cw & hpd_pkg::MaskP8) ^ cw_beat.cw[hpd_pkg::ParBitP8];
   end

   // position p sits at codeword bit CwWidth - p
   always_comb begin
      for (int b = 0; b < hpd_pkg::CwWidth; b++) begin
         flip[b] = correct_mode &&
                   (syn == hpd_pkg::SynWidth'(hpd_pkg::CwWidth - b));
      end
   end

   always_comb begin
      fixed_cw = cw_beat.cw ^ flip;
      data_in  = {fixed_cw[9], fixed_cw[7:5], fixed_cw[3:0]};
      err_in   = (syn != '0);
      bad_in   = (syn > hpd_pkg::LastCorrectable);
      valid_in = load || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= data_in;
         syn_ff  <= syn;
         err_ff  <= err_in;
         bad_ff  <= bad_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_syndrome      = syn_ff;
   assign rsp_error_flag    = err_ff;
   assign rsp_uncorrectable = bad_ff;

endmodule

/* sv/hamming_12_8_packed_decoder_core.sv */
// ----------------------------------------------------------------------------
// hamming_12_8_packed_decoder_core: packed Hamming(12,8) SEC decoder
// Unpacks two 12-bit codewords from every three code bytes and decodes them.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one code byte per beat. Bytes A, B, C of a group carry the
//            codewords {A, B[7:4]} and {B[3:0], C}.
//   rsp_*  : one decoded beat per completed codeword (on bytes B and C),
//            with data byte, syndrome, error flag and uncorrectable flag.
//   csr_*  : APB-style port; register 0 at byte address 0 holds
//            correct_mode (0 flag only, 1 correct single-bit errors).
// Pipeline: a closing byte's codeword goes to the codeword register, then
//   its result beat to the result register.
// Throughput: one byte per cycle while the result side keeps up; the
//   syndrome tree and correction are combinational between the registers.
// Reset: byte phase returns to the start of a group, no beat is pending,
//   correct_mode clears to 0.
// Stall: while rsp_ready is low the result holds; one more codeword can
//   wait in the codeword register, then req_ready drops.
// ----------------------------------------------------------------------------
module hamming_12_8_packed_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [hpd_pkg::CodeByteWidth-1:0] req_code_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [hpd_pkg::CodeByteWidth-1:0] rsp_data_byte,
   output logic [hpd_pkg::SynWidth-1:0]      rsp_syndrome,
   output logic                              rsp_error_flag,
   output logic                              rsp_uncorrectable,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hpd_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [hpd_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [hpd_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);

   logic                  correct_mode;
   hpd_pkg::cw_beat_type  cw_beat;
   logic                  cw_ready;

   hpd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .correct_mode (correct_mode)
   );

   hpd_unpack u_unpack (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_byte (req_code_byte),
      .cw_beat       (cw_beat),
      .cw_ready      (cw_ready)
   );

   hpd_decode u_decode (
      .clock             (clock),
      .reset             (reset),
      .cw_beat           (cw_beat),
      .cw_ready          (cw_ready),
      .correct_mode      (correct_mode),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_syndrome      (rsp_syndrome),
      .rsp_error_flag    (rsp_error_flag),
      .rsp_uncorrectable (rsp_uncorrectable)
   );

endmodule

/* sv/hpd_checker.sv */
// ----------------------------------------------------------------------------
// hpd_checker: port-level checks for the packed Hamming(12,8) decoder
// Watches the top-level ports and flags inconsistent result beats and changed stalled code bytes.
// ----------------------------------------------------------------------------
module hpd_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [hpd_pkg::CodeByteWidth-1:0] req_code_byte,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [hpd_pkg::CodeByteWidth-1:0] rsp_data_byte,
   input  logic [hpd_pkg::SynWidth-1:0]      rsp_syndrome,
   input  logic                              rsp_error_flag,
   input  logic                              rsp_uncorrectable
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_error_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_error_flag == (rsp_syndrome != '0)))
      else $error("error flag disagrees with syndrome");

   a_uncorrectable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_uncorrectable == (rsp_syndrome > hpd_pkg::LastCorrectable)))
      else $error("uncorrectable flag disagrees with syndrome");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_data_byte) && $stable(rsp_syndrome)))
      else $error("stalled result beat changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_code_byte)))
      else $error("stalled code byte beat changed");

endmodule

bind hamming_12_8_packed_decoder_core hpd_checker u_hpd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_code_byte     (req_code_byte),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_data_byte     (rsp_data_byte),
   .rsp_syndrome      (rsp_syndrome),
   .rsp_error_flag    (rsp_error_flag),
   .rsp_uncorrectable (rsp_uncorrectable)
);

/* bench/hpd_decode_checker.sv */
// ----------------------------------------------------------------------------
// hpd_decode_checker: scoreboard for the packed Hamming(12,8) decoder
// Watches the code byte, result and register channels, rebuilds each
// codeword from the byte stream, predicts its decoded beat and compares
// every accepted result beat, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module hpd_decode_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [hpd_pkg::CodeByteWidth-1:0] req_code_byte,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [hpd_pkg::CodeByteWidth-1:0] rsp_data_byte,
   input  logic [hpd_pkg::SynWidth-1:0]      rsp_syndrome,
   input  logic                              rsp_error_flag,
   input  logic                              rsp_uncorrectable,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hpd_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [hpd_pkg::CsrDataWidth-1:0]  csr_pwdata,
   input  logic                              csr_pready,
   output int                                fail_count,
   output int                                pending_count
);

   typedef struct packed {
      logic [hpd_pkg::CodeByteWidth-1:0] data_byte;
      logic [hpd_pkg::SynWidth-1:0]      syndrome;
      logic                              error_flag;
      logic                              uncorrectable;
   } decoded_beat_type;

   typedef enum logic [1:0] {
      EXPECT_A = 2'd0,
      EXPECT_B = 2'd1,
      EXPECT_C = 2'd2
   } group_phase_type;

   localparam logic [hpd_pkg::CsrAddrWidth-1:0] ModeAddr =
      hpd_pkg::CsrAddrWidth'(4 * int'(hpd_pkg::CSR_CORRECT_MODE));

   decoded_beat_type                  expected_beats[$];
   group_phase_type                   byte_phase;
   logic [hpd_pkg::CodeByteWidth-1:0] held_bits;
   logic                              fix_enabled;
   int                                mismatches;

   function automatic decoded_beat_type decode_codeword(
      input logic [hpd_pkg::CwWidth-1:0] cw_in,
      input logic                        fix);
      logic [hpd_pkg::CwWidth-1:0]  cw;
      logic [hpd_pkg::SynWidth-1:0] syn;
      decoded_beat_type             beat;
      cw = cw_in;
      syn[0] = (^(cw & hpd_pkg::MaskP1)) ^ cw[hpd_pkg::ParBitP1];
      syn[1] = (^(cw & hpd_pkg::MaskP2)) ^ cw[hpd_pkg::ParBitP2];
      syn[2] = (^(cw & hpd_pkg::MaskP4)) ^ cw[hpd_pkg::ParBitP4];
      syn[3] = (^(cw & hpd_pkg::MaskP8)) ^ cw[hpd_pkg::ParBitP8];
      beat.syndrome      = syn;
      beat.error_flag    = (syn != '0);
      beat.uncorrectable = (syn > hpd_pkg::LastCorrectable);
      if (fix && beat.error_flag && !beat.uncorrectable) begin
         cw = cw ^ (12'd1 << (12 - int'(syn)));
      end
      beat.data_byte = {cw[9], cw[7:5], cw[3:0]};
      return beat;
   endfunction

   initial begin
      fail_count    = 0;
      pending_count = 0;
      mismatches    = 0;
      byte_phase    = EXPECT_A;
      held_bits     = '0;
      fix_enabled   = 1'b0;
   end

   always @(posedge clock) begin : watch
      decoded_beat_type            got;
      decoded_beat_type            want;
      logic [hpd_pkg::CwWidth-1:0] cw;
      if (reset) begin
         byte_phase  = EXPECT_A;
         held_bits   = '0;
         fix_enabled = 1'b0;
         expected_beats.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == ModeAddr) begin
            fix_enabled = csr_pwdata[0];
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_data_byte, rsp_syndrome, rsp_error_flag, rsp_uncorrectable};
            if (expected_beats.size() == 0) begin
               if (mismatches < 10) begin
                  $display("result beat with none expected: data %h syn %0d err %b unc %b",
                           got.data_byte, got.syndrome, got.error_flag, got.uncorrectable);
               end
               mismatches++;
            end else begin
               want = expected_beats.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display("mismatch: data %h/%h syn %0d/%0d err %b/%b unc %b/%b (exp/act)",
                              want.data_byte, got.data_byte, want.syndrome, got.syndrome,
                              want.error_flag, got.error_flag,
                              want.uncorrectable, got.uncorrectable);
                  end
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (byte_phase)
               EXPECT_B: begin
                  cw = {held_bits, req_code_byte[7:4]};
                  held_bits = {4'd0, req_code_byte[3:0]};
                  byte_phase = EXPECT_C;
                  expected_beats.push_back(decode_codeword(cw, fix_enabled));
               end
               EXPECT_C: begin
                  cw = {held_bits[3:0], req_code_byte};
                  byte_phase = EXPECT_A;
                  expected_beats.push_back(decode_codeword(cw, fix_enabled));
               end
               default: begin
                  held_bits = req_code_byte;
                  byte_phase = EXPECT_B;
               end
            endcase
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_beats.size();
   end

endmodule

/* bench/tb_hamming_12_8_packed_decoder_core.sv */
// ----------------------------------------------------------------------------
// tb_hamming_12_8_packed_decoder_core: testbench for the packed decoder
// Drives directed codewords for every syndrome, half in each mode, then
// random packed streams under alternating mode settings, with bursty input,
// patterned output stalls and periodic long output holds that back up the input.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_hamming_12_8_packed_decoder_core;

   typedef enum int {
      RX_STREAM = 0,
      RX_COIN   = 1,
      RX_SPARSE = 2,
      RX_TOGGLE = 3
   } rx_pattern_type;

   localparam logic MODE_DETECT  = 1'b0;
   localparam logic MODE_CORRECT = 1'b1;
   localparam logic [hpd_pkg::CsrAddrWidth-1:0] ModeAddr =
      hpd_pkg::CsrAddrWidth'(4 * int'(hpd_pkg::CSR_CORRECT_MODE));

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [hpd_pkg::CodeByteWidth-1:0] req_code_byte;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [hpd_pkg::CodeByteWidth-1:0] rsp_data_byte;
   logic [hpd_pkg::SynWidth-1:0]      rsp_syndrome;
   logic                              rsp_error_flag;
   logic                              rsp_uncorrectable;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [hpd_pkg::CsrAddrWidth-1:0]  csr_paddr;
   logic [hpd_pkg::CsrDataWidth-1:0]  csr_pwdata;
   logic [hpd_pkg::CsrDataWidth-1:0]  csr_prdata;
   logic                              csr_pready;
   int                                fail_count;
   int                                pending_count;
   logic                              in_random;
   int                                burst_left;

   hamming_12_8_packed_decoder_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_code_byte     (req_code_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_syndrome      (rsp_syndrome),
      .rsp_error_flag    (rsp_error_flag),
      .rsp_uncorrectable (rsp_uncorrectable),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   hpd_decode_checker decode_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_code_byte     (req_code_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_syndrome      (rsp_syndrome),
      .rsp_error_flag    (rsp_error_flag),
      .rsp_uncorrectable (rsp_uncorrectable),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .fail_count        (fail_count),
      .pending_count     (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [hpd_pkg::CwWidth-1:0] encode_byte(
      input logic [hpd_pkg::CodeByteWidth-1:0] d);
      logic [hpd_pkg::CwWidth-1:0] cw;
      cw = '0;
      cw[9]   = d[7];
      cw[7:5] = d[6:4];
      cw[3:0] = d[3:0];
      cw[hpd_pkg::ParBitP1] = ^(cw & hpd_pkg::MaskP1);
      cw[hpd_pkg::ParBitP2] = ^(cw & hpd_pkg::MaskP2);
      cw[hpd_pkg::ParBitP4] = ^(cw & hpd_pkg::MaskP4);
      cw[hpd_pkg::ParBitP8] = ^(cw & hpd_pkg::MaskP8);
      return cw;
   endfunction

   function automatic logic [hpd_pkg::CwWidth-1:0] random_codeword();
      logic [hpd_pkg::CwWidth-1:0] cw;
      int pick;
      pick = $urandom_range(0, 9);
      cw = encode_byte(8'($urandom));
      if (pick >= 3 && pick < 7) begin
         cw[$urandom_range(0, hpd_pkg::CwWidth-1)] ^= 1'b1;
      end else if (pick == 7) begin
         cw[$urandom_range(0, 5)] ^= 1'b1;
         cw[$urandom_range(6, hpd_pkg::CwWidth-1)] ^= 1'b1;
      end else if (pick > 7) begin
         cw = 12'($urandom);
      end
      return cw;
   endfunction

   task automatic send_byte(input logic [hpd_pkg::CodeByteWidth-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid     = 1'b0;
            req_code_byte = 8'($urandom);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid     = 1'b1;
      req_code_byte = b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_pair(input logic [hpd_pkg::CwWidth-1:0] cw1,
                            input logic [hpd_pkg::CwWidth-1:0] cw2);
      send_byte(cw1[11:4]);
      send_byte({cw1[3:0], cw2[11:8]});
      send_byte(cw2[7:0]);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_mode(input logic mode);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = ModeAddr;
      csr_pwdata  = {31'($urandom), mode};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // output side: patterned stalls plus a periodic long hold
   initial begin : receiver
      rx_pattern_type pattern;
      int pattern_left;
      int hold_left;
      int random_cycles;
      pattern       = RX_STREAM;
      pattern_left  = 0;
      hold_left     = 0;
      random_cycles = 0;
      rsp_ready     = 1'b0;
      forever begin
         @(negedge clock);
         if (in_random) begin
            random_cycles++;
            if (random_cycles % 400 == 50) hold_left = 60;
         end
         if (pattern_left == 0) begin
            pattern      = rx_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(16, 64);
         end
         pattern_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready = 1'b0;
         end else begin
            case (pattern)
               RX_STREAM: rsp_ready = 1'b1;
               RX_COIN:   rsp_ready = 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ready = ($urandom_range(0, 4) == 0);
               default:   rsp_ready = ~rsp_ready;
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [hpd_pkg::CwWidth-1:0] directed_cw[16];
      logic                        phase_mode[4];
      int                          i;
      int                          p;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_code_byte = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      in_random     = 1'b0;
      burst_left    = 0;
      phase_mode    = '{MODE_DETECT, MODE_CORRECT, MODE_DETECT, MODE_CORRECT};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // one codeword per syndrome value; the top three need a double flip
      for (i = 0; i < 16; i++) begin
         if (i == 0) directed_cw[i] = encode_byte(8'h00);
         else if (i == 15) directed_cw[i] = encode_byte(8'hFF);
         else directed_cw[i] = encode_byte(8'($urandom));
         if (i >= 1 && i <= 12) directed_cw[i][12 - i] ^= 1'b1;
         else if (i >= 13) directed_cw[i] ^= (12'h001 | (12'h001 << (24 - i)));
      end
      for (i = 0; i < 4; i++) send_pair(directed_cw[2*i], directed_cw[2*i+1]);
      drain();
      write_mode(MODE_CORRECT);
      for (i = 4; i < 8; i++) send_pair(directed_cw[2*i], directed_cw[2*i+1]);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hFF);

      in_random = 1'b1;
      for (p = 0; p < 4; p++) begin
         drain();
         write_mode(phase_mode[p]);
         for (i = 0; i < 40; i++) send_pair(random_codeword(), random_codeword());
         // leave the group open across the next mode write; phase 2 closes it again
         if (p == 1) send_byte(8'($urandom));
         if (p == 2) begin
            send_byte(8'($urandom));
            send_byte(8'($urandom));
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
